### src/psc_pkg.sv
package psc_pkg;

    localparam int CHANNELS_DEF = 2;
    localparam int LEVEL_W      = 4;
    localparam int SUM_W        = 5;
    localparam int PERIOD_W     = 11;

    localparam logic [1:0] CMD_WRITE  = 2'd0;
    localparam logic [1:0] CMD_TIMER  = 2'd1;
    localparam logic [1:0] CMD_FRAME  = 2'd2;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    localparam logic [1:0] REG_DUTY_ENV = 2'd0;
    localparam logic [1:0] REG_SWEEP    = 2'd1;
    localparam logic [1:0] REG_TIMER_LO = 2'd2;
    localparam logic [1:0] REG_LEN_HI   = 2'd3;

    localparam logic [0:0] CFG_ENABLE    = 1'd0;
    localparam logic [0:0] CFG_FIVE_STEP = 1'd1;

    // per-channel request, decoded separately for each channel slice
    typedef struct packed {
        logic       wr;
        logic [1:0] sel;
        logic [7:0] data;
        logic       timer;
        logic       quarter;
        logic       half;
    } chan_ctl_t;

    function automatic logic [7:0] duty_pattern(input logic [1:0] d);
        logic [7:0] r;
        case (d)
            2'd0:    r = 8'h40;
            2'd1:    r = 8'h60;
            2'd2:    r = 8'h78;
            default: r = 8'h9F;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] length_lookup(input logic [4:0] i);
        logic [7:0] r;
        case (i)
            5'd0:  r = 8'h0A; 5'd1:  r = 8'hFE; 5'd2:  r = 8'h14; 5'd3:  r = 8'h02;
            5'd4:  r = 8'h28; 5'd5:  r = 8'h04; 5'd6:  r = 8'h50; 5'd7:  r = 8'h06;
            5'd8:  r = 8'hA0; 5'd9:  r = 8'h08; 5'd10: r = 8'h3C; 5'd11: r = 8'h0A;
            5'd12: r = 8'h0E; 5'd13: r = 8'h0C; 5'd14: r = 8'h1A; 5'd15: r = 8'h0E;
            5'd16: r = 8'h0C; 5'd17: r = 8'h10; 5'd18: r = 8'h18; 5'd19: r = 8'h12;
            5'd20: r = 8'h30; 5'd21: r = 8'h14; 5'd22: r = 8'h60; 5'd23: r = 8'h16;
            5'd24: r = 8'hC0; 5'd25: r = 8'h18; 5'd26: r = 8'h48; 5'd27: r = 8'h1A;
            5'd28: r = 8'h10; 5'd29: r = 8'h1C; 5'd30: r = 8'h20;
            default: r = 8'h1E;
        endcase
        return r;
    endfunction

endpackage

### src/psc_channel.sv
module psc_channel (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   load_en,
    input  logic                   ctl_valid,
    input  psc_pkg::chan_ctl_t     ctl,
    output logic [psc_pkg::LEVEL_W-1:0] level
);

    logic [1:0]  duty_reg;
    logic        halt_reg, cvol_reg;
    logic [3:0]  vol_reg;
    logic        sw_en_reg, sw_neg_reg, sw_reload_reg;
    logic [2:0]  sw_period_reg, sw_shift_reg, sw_count_reg;
    logic [10:0] period_reg, tcount_reg;
    logic [2:0]  pos_reg;
    logic [7:0]  len_reg;
    logic        env_start_reg;
    logic [3:0]  env_level_reg, env_period_reg, env_count_reg;

    logic [10:0] delta;
    logic [7:0]  duty_bits;

    assign delta     = period_reg >> sw_shift_reg;
    assign duty_bits = psc_pkg::duty_pattern(duty_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            duty_reg <= '0; halt_reg <= 1'b0; cvol_reg <= 1'b0; vol_reg <= '0;
            sw_en_reg <= 1'b0; sw_neg_reg <= 1'b0; sw_reload_reg <= 1'b0;
            sw_period_reg <= '0; sw_shift_reg <= '0; sw_count_reg <= '0;
            period_reg <= '0; tcount_reg <= '0; pos_reg <= '0; len_reg <= '0;
            env_start_reg <= 1'b0; env_level_reg <= '0; env_period_reg <= '0;
            env_count_reg <= '0;
        end else if (ctl_valid) begin
            if (ctl.wr) begin
                case (ctl.sel)
                    psc_pkg::REG_DUTY_ENV: begin
                        duty_reg <= ctl.data[7:6];
                        halt_reg <= ctl.data[5];
                        cvol_reg <= ctl.data[4];
                        vol_reg  <= ctl.data[3:0];
                    end
                    psc_pkg::REG_SWEEP: begin
                        sw_en_reg     <= ctl.data[7];
                        sw_period_reg <= ctl.data[6:4];
                        sw_neg_reg    <= ctl.data[3];
                        sw_shift_reg  <= ctl.data[2:0];
                        sw_reload_reg <= 1'b1;
                    end
                    psc_pkg::REG_TIMER_LO: period_reg[7:0] <= ctl.data;
                    default: begin
                        period_reg[10:8] <= ctl.data[2:0];
                        if (load_en) len_reg <= psc_pkg::length_lookup(ctl.data[7:3]);
                        env_start_reg <= 1'b1;
                    end
                endcase
            end
            if (ctl.timer) begin
                if (tcount_reg == '0) begin
                    pos_reg    <= pos_reg + 3'd1;
                    tcount_reg <= period_reg;
                end else begin
                    tcount_reg <= tcount_reg - 11'd1;
                end
            end
            if (ctl.half) begin
                if (len_reg != '0 && !halt_reg) len_reg <= len_reg - 8'd1;
                if (sw_reload_reg) begin
                    sw_count_reg  <= sw_period_reg;
                    sw_reload_reg <= 1'b0;
                end else if (sw_count_reg != '0) begin
                    sw_count_reg <= sw_count_reg - 3'd1;
                end else if (sw_en_reg) begin
                    sw_count_reg <= sw_period_reg;
                    period_reg   <= sw_neg_reg ? period_reg - delta : period_reg + delta;
                end
            end
            if (ctl.quarter) begin
                if (env_start_reg) begin
                    env_start_reg  <= 1'b0;
                    env_level_reg  <= 4'd15;
                    env_period_reg <= vol_reg;
                end else if (env_count_reg == '0) begin
                    env_count_reg <= env_period_reg;
                    if (halt_reg) env_level_reg <= 4'd15;
                    else if (env_level_reg != '0) env_level_reg <= env_level_reg - 4'd1;
                end else begin
                    env_count_reg <= env_count_reg - 4'd1;
                end
            end
        end
    end

    // muted on empty length, ultrasonic period, or low duty bit
    always_comb begin
        if (len_reg == '0 || period_reg < 11'd8 || !duty_bits[pos_reg])
            level = '0;
        else
            level = cvol_reg ? vol_reg : env_level_reg;
    end

endmodule

### src/pulse_sound_channels_unit.sv
// Two pulse sound channels with a shared frame sequencer.
// Request channel s_axis: tdata[7:0] = write_data (command, channel and
// register_select ride in tuser). Each request is a register write, a
// timer tick, a frame sequencer tick or an unused no-op; every request yields one result.
// Result channel m_axis: tdata = first_level, second_level, level_sum.
// The result is valid the cycle after the request is accepted (channel
// state updates at the accept edge, levels are decoded from that
// registered state).
// Throughput: one request per clock; s_tready only drops when a result is
// held and m_tready is low, so a stalled receiver holds the result steady
// (no state moves while the input is blocked) and back-pressures the input.
// Config: cfg_we/cfg_index/cfg_wdata write channel_enable (index 0) and
// frame_five_step (index 1), taken at any edge with cfg_we high.
// Reset (aresetn low, synchronous) clears all channel and sequencer state
// and empties the result register.
module pulse_sound_channels_unit #(
    parameter int CHANNELS = psc_pkg::CHANNELS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [1:0]  cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] write_data
    input  logic [4:0]  s_tuser,   // [1:0] command, [2] channel, [4:3] register_select
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // [3:0] first, [7:4] second, [12:8] sum
);

    logic [CHANNELS-1:0] enable_reg;
    logic                five_reg;
    logic [2:0]          step_reg, step_next;
    logic                m_valid_reg;

    logic       accept;
    logic [1:0] cmd;
    logic       quarter, half;
    logic [psc_pkg::LEVEL_W-1:0] lvl [CHANNELS];
    logic [psc_pkg::LEVEL_W-1:0] lvl_a, lvl_b;
    logic [psc_pkg::SUM_W-1:0]   lvl_sum;

    assign s_tready = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign cmd      = s_tuser[1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg <= '0;
            five_reg   <= 1'b0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                psc_pkg::CFG_ENABLE:    enable_reg <= CHANNELS'(cfg_wdata);
                psc_pkg::CFG_FIVE_STEP: five_reg   <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // frame sequencer decode
    always_comb begin
        if (five_reg) begin
            half      = (step_reg == 3'd0) || (step_reg == 3'd2);
            quarter   = step_reg <= 3'd3;
            step_next = (step_reg >= 3'd4) ? 3'd0 : step_reg + 3'd1;
        end else begin
            half      = (step_reg == 3'd1) || (step_reg == 3'd3);
            quarter   = 1'b1;
            step_next = (step_reg + 3'd1) & 3'd3;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) step_reg <= '0;
        else if (accept && cmd == psc_pkg::CMD_FRAME) step_reg <= step_next;
    end

    genvar c;
    generate
        for (c = 0; c < CHANNELS; c++) begin : g_ch
            psc_pkg::chan_ctl_t cc;
            always_comb begin
                cc         = '0;
                cc.wr      = (cmd == psc_pkg::CMD_WRITE) && (s_tuser[2] == c[0])
                             && (c < 2);
                cc.sel     = s_tuser[4:3];
                cc.data    = s_tdata;
                cc.timer   = cmd == psc_pkg::CMD_TIMER;
                cc.quarter = (cmd == psc_pkg::CMD_FRAME) && quarter;
                cc.half    = (cmd == psc_pkg::CMD_FRAME) && half;
            end
            psc_channel u_ch (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .load_en   (enable_reg[c]),
                .ctl_valid (accept),
                .ctl       (cc),
                .level     (lvl[c])
            );
        end
    endgenerate

    // levels follow the state written at the accept edge; state only moves on
    // an accept, so a held result stays put
    assign lvl_a   = lvl[0];
    assign lvl_b   = (CHANNELS >= 2) ? lvl[(CHANNELS >= 2) ? 1 : 0] : '0;
    assign lvl_sum = {1'b0, lvl_a} + {1'b0, lvl_b};

    always_ff @(posedge aclk) begin
        if (!aresetn) m_valid_reg <= 1'b0;
        else if (accept) m_valid_reg <= 1'b1;
        else if (m_tready) m_valid_reg <= 1'b0;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {3'd0, lvl_sum, lvl_b, lvl_a};

    a_sum: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[12:8] == {1'b0, m_tdata[3:0]} + {1'b0, m_tdata[7:4]})
        else $error("level sum mismatch");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result lost under stall");
    a_step: assert property (@(posedge aclk) disable iff (!aresetn)
        step_reg <= 3'd4)
        else $error("frame step out of range");

endmodule

### bench/pulse_sound_channels_unit_tb.sv
`timescale 1ns / 1ps

// Self-checking bench for the two pulse sound channels.
// Requests (register writes, timer ticks, frame ticks) go in on s_*,
// a software copy of the channel and sequencer state predicts the levels,
// and every result on m_* is checked against the oldest prediction.
module pulse_sound_channels_unit_tb;

    typedef struct packed {
        logic [3:0] first;
        logic [3:0] second;
        logic [4:0] total;
    } levels_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic [0:0]  cfg_index = '0;
    logic [1:0]  cfg_wdata = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;   // [7:0] write_data
    logic [4:0]  s_tuser = '0;   // [1:0] command, [2] channel, [4:3] register_select
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;        // [3:0] first, [7:4] second, [12:8] sum

    pulse_sound_channels_unit dut (.*);

    always #5 aclk = ~aclk;

    // predictor state
    logic [1:0]  ena_bits;
    logic        five_step;
    logic [1:0]  duty_sel [2];
    logic        halt_loop [2];
    logic        const_vol [2];
    logic [3:0]  vol_env [2];
    logic        swp_en [2];
    logic [2:0]  swp_per [2];
    logic        swp_neg [2];
    logic [2:0]  swp_shift [2];
    logic        swp_reload [2];
    logic [2:0]  swp_cnt [2];
    logic [10:0] tmr_per [2];
    logic [10:0] tmr_cnt [2];
    logic [2:0]  duty_pos [2];
    logic [7:0]  len_cnt [2];
    logic        env_start [2];
    logic [3:0]  env_lvl [2];
    logic [3:0]  env_per [2];
    logic [3:0]  env_cnt [2];
    logic [2:0]  seq_step;

    levels_t pending_levels[$];
    int  mismatches = 0;
    int  idle_cycles = 0;
    bit  calm = 0;      // no random idling in the last part
    int  rx_hold = 0;   // stall cycles still to come after the current one

    localparam logic [7:0] DUTY_WAVE [4] = '{8'h40, 8'h60, 8'h78, 8'h9F};
    localparam logic [7:0] LEN_LOAD [32] = '{
        8'h0A, 8'hFE, 8'h14, 8'h02, 8'h28, 8'h04, 8'h50, 8'h06,
        8'hA0, 8'h08, 8'h3C, 8'h0A, 8'h0E, 8'h0C, 8'h1A, 8'h0E,
        8'h0C, 8'h10, 8'h18, 8'h12, 8'h30, 8'h14, 8'h60, 8'h16,
        8'hC0, 8'h18, 8'h48, 8'h1A, 8'h10, 8'h1C, 8'h20, 8'h1E};

    task automatic clear_model();
        ena_bits = '0; five_step = 1'b0; seq_step = '0;
        for (int c = 0; c < 2; c++) begin
            duty_sel[c] = '0; halt_loop[c] = 1'b0; const_vol[c] = 1'b0; vol_env[c] = '0;
            swp_en[c] = 1'b0; swp_per[c] = '0; swp_neg[c] = 1'b0; swp_shift[c] = '0;
            swp_reload[c] = 1'b0; swp_cnt[c] = '0; tmr_per[c] = '0; tmr_cnt[c] = '0;
            duty_pos[c] = '0; len_cnt[c] = '0; env_start[c] = 1'b0; env_lvl[c] = '0;
            env_per[c] = '0; env_cnt[c] = '0;
        end
    endtask

    task automatic half_frame();
        logic [10:0] delta;
        for (int c = 0; c < 2; c++) begin
            if (len_cnt[c] != 0 && !halt_loop[c]) len_cnt[c]--;
            if (swp_reload[c]) begin
                swp_cnt[c] = swp_per[c];
                swp_reload[c] = 1'b0;
            end else if (swp_cnt[c] != 0) begin
                swp_cnt[c]--;
            end else if (swp_en[c]) begin
                delta = tmr_per[c] >> swp_shift[c];
                swp_cnt[c] = swp_per[c];
                tmr_per[c] = swp_neg[c] ? tmr_per[c] - delta : tmr_per[c] + delta;
            end
        end
    endtask

    task automatic quarter_frame();
        for (int c = 0; c < 2; c++) begin
            if (env_start[c]) begin
                env_start[c] = 1'b0;
                env_lvl[c] = 4'd15;
                env_per[c] = vol_env[c];  // divider count left alone
            end else if (env_cnt[c] == 0) begin
                env_cnt[c] = env_per[c];
                if (halt_loop[c]) env_lvl[c] = 4'd15;
                else if (env_lvl[c] != 0) env_lvl[c]--;
            end else begin
                env_cnt[c]--;
            end
        end
    endtask

    function automatic logic [3:0] chan_level(int c);
        if (len_cnt[c] == 0 || tmr_per[c] < 8) return 4'd0;
        if (!DUTY_WAVE[duty_sel[c]][duty_pos[c]]) return 4'd0;
        return const_vol[c] ? vol_env[c] : env_lvl[c];
    endfunction

    // advance the channel model by one request and queue the levels it gives
    task automatic predict_levels(logic [1:0] cmd, logic ch, logic [1:0] sel,
                                  logic [7:0] v);
        levels_t lv;
        case (cmd)
            psc_pkg::CMD_WRITE: begin
                case (sel)
                    psc_pkg::REG_DUTY_ENV: begin
                        duty_sel[ch] = v[7:6]; halt_loop[ch] = v[5];
                        const_vol[ch] = v[4]; vol_env[ch] = v[3:0];
                    end
                    psc_pkg::REG_SWEEP: begin
                        swp_en[ch] = v[7]; swp_per[ch] = v[6:4];
                        swp_neg[ch] = v[3]; swp_shift[ch] = v[2:0];
                        swp_reload[ch] = 1'b1;
                    end
                    psc_pkg::REG_TIMER_LO: tmr_per[ch][7:0] = v;
                    default: begin
                        tmr_per[ch][10:8] = v[2:0];
                        if (ena_bits[ch]) len_cnt[ch] = LEN_LOAD[v[7:3]];
                        env_start[ch] = 1'b1;
                    end
                endcase
            end
            psc_pkg::CMD_TIMER: begin
                for (int c = 0; c < 2; c++) begin
                    if (tmr_cnt[c] == 0) begin
                        duty_pos[c]++;
                        tmr_cnt[c] = tmr_per[c];
                    end else begin
                        tmr_cnt[c]--;
                    end
                end
            end
            psc_pkg::CMD_FRAME: begin
                if (five_step) begin
                    if (seq_step == 0 || seq_step == 2) half_frame();
                    if (seq_step <= 3) quarter_frame();
                    seq_step = (seq_step == 3'd4) ? 3'd0 : seq_step + 3'd1;
                end else begin
                    // a leftover step 4 wraps to 1 without a half frame
                    if (seq_step == 1 || seq_step == 3) half_frame();
                    quarter_frame();
                    seq_step = (seq_step + 3'd1) & 3'd3;
                end
            end
            default: ;  // unused command: nothing changes
        endcase
        lv.first = chan_level(0);
        lv.second = chan_level(1);
        lv.total = lv.first + lv.second;
        pending_levels.push_back(lv);
    endtask

    task automatic set_reg(logic [0:0] idx, logic [1:0] val);
        @(negedge aclk);
        cfg_we <= 1'b1; cfg_index <= idx; cfg_wdata <= val;
        @(negedge aclk);
        cfg_we <= 1'b0;
        if (idx == psc_pkg::CFG_ENABLE) ena_bits = val;
        else five_step = val[0];
    endtask

    // called at a falling edge right after the last request
    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_levels.size() != 0) @(negedge aclk);
        repeat (3) @(negedge aclk);
    endtask

    // drive one request; called at a falling edge, returns at a falling edge
    // with s_tvalid still high so requests can follow back to back
    task automatic send_request(logic [1:0] cmd, logic ch, logic [1:0] sel,
                                logic [7:0] v);
        if (!calm && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= {sel, ch, cmd};
        s_tdata <= v;
        do @(posedge aclk); while (!s_tready);
        predict_levels(cmd, ch, sel, v);
        @(negedge aclk);
    endtask

    task automatic write_reg(logic ch, logic [1:0] sel, logic [7:0] v);
        send_request(psc_pkg::CMD_WRITE, ch, sel, v);
    endtask

    // result checker
    always @(posedge aclk) begin
        levels_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = {m_tdata[3:0], m_tdata[7:4], m_tdata[12:8]};
            if (pending_levels.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h", m_tdata);
            end else begin
                want = pending_levels.pop_front();
                if (got !== want || m_tdata[15:13] !== 3'b0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("levels: expected %0d/%0d/%0d got %0d/%0d/%0d",
                                 want.first, want.second, want.total,
                                 got.first, got.second, got.total);
                end
            end
        end
    end

    // receiver stalls in random bursts
    always @(negedge aclk) begin
        if (calm) m_tready <= 1'b1;
        else if (rx_hold > 0) begin
            m_tready <= 1'b0;
            rx_hold--;
        end else if ($urandom_range(0, 6) == 0) begin
            m_tready <= 1'b0;
            rx_hold = $urandom_range(0, 2);
        end else begin
            m_tready <= 1'b1;
        end
    end

    // watchdog on cycles with no accepted request or result
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn)
            idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 2000) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // directed: extremes of each register and every command
    task automatic test_directed();
        set_reg(psc_pkg::CFG_ENABLE, 2'd3);
        write_reg(1'b0, psc_pkg::REG_DUTY_ENV, 8'hFF);
        write_reg(1'b1, psc_pkg::REG_DUTY_ENV, 8'h00);
        write_reg(1'b0, psc_pkg::REG_TIMER_LO, 8'hFF);
        write_reg(1'b1, psc_pkg::REG_TIMER_LO, 8'h08);
        write_reg(1'b0, psc_pkg::REG_LEN_HI, 8'hFF);
        write_reg(1'b1, psc_pkg::REG_LEN_HI, 8'h08);
        write_reg(1'b0, psc_pkg::REG_SWEEP, 8'hFF);
        write_reg(1'b1, psc_pkg::REG_SWEEP, 8'h80);
        repeat (3) send_request(psc_pkg::CMD_TIMER, 1'b0, 2'd0, 8'h00);
        repeat (5) send_request(psc_pkg::CMD_FRAME, 1'b0, 2'd0, 8'h00);
        send_request(psc_pkg::CMD_UNUSED, 1'b1, 2'd3, 8'hFF);
        write_reg(1'b1, psc_pkg::REG_TIMER_LO, 8'h07);    // period under 8 mutes
        write_reg(1'b0, psc_pkg::REG_DUTY_ENV, 8'h30);
        repeat (3) send_request(psc_pkg::CMD_TIMER, 1'b0, 2'd0, 8'h00);
        drain();
    endtask

    // random content; mostly ticks with enough writes to keep channels alive
    task automatic test_random(int n, logic [1:0] ena, logic five);
        int r;
        logic [1:0] cmd;
        set_reg(psc_pkg::CFG_ENABLE, ena);
        set_reg(psc_pkg::CFG_FIVE_STEP, {1'b0, five});
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 9);
            if (r < 3) cmd = psc_pkg::CMD_WRITE;
            else if (r < 7) cmd = psc_pkg::CMD_TIMER;
            else if (r < 9) cmd = psc_pkg::CMD_FRAME;
            else cmd = psc_pkg::CMD_UNUSED;
            send_request(cmd, 1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
                         8'($urandom_range(0, 255)));
        end
        drain();
    endtask

    // mode switch mid-sequence leaves the step count as it is
    task automatic test_mode_switch();
        set_reg(psc_pkg::CFG_FIVE_STEP, 2'd1);
        repeat (4) send_request(psc_pkg::CMD_FRAME, 1'b0, 2'd0, 8'h00);
        drain();
        set_reg(psc_pkg::CFG_FIVE_STEP, 2'd0);
        repeat (3) send_request(psc_pkg::CMD_FRAME, 1'b0, 2'd0, 8'h00);
        drain();
    endtask

    initial begin
        clear_model();
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        test_directed();
        test_mode_switch();
        test_random(150, 2'd1, 1'b0);
        test_random(150, 2'd2, 1'b1);
        test_random(150, 2'd0, 1'b0);
        calm = 1;
        test_random(150, 2'd3, 1'b1);
        if (mismatches == 0 && pending_levels.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule
